### design/sita_pkg.sv
// ----------------------------------------------------------------------------
// sita_pkg
// Shared widths, register indexes and the word type that moves along the
// cell row of the strided index to address generator.
// ----------------------------------------------------------------------------
package sita_pkg;

    localparam int MAX_DIMS  = 3;
    localparam int REG_DIMS  = 3;
    localparam int DIM_LIM   = (MAX_DIMS < REG_DIMS) ? MAX_DIMS : REG_DIMS;

    localparam int IDX_W     = 48;
    localparam int ADDR_W    = 50;
    localparam int SIZE_W    = 16;
    localparam int STRIDE_W  = 32;
    localparam int BASE_W    = 32;
    localparam int PROD_W    = SIZE_W + STRIDE_W;
    localparam int DIM_CNT_W = 2;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_D0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_D1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_D2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_D0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_D1 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_D2 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BASE      = 3'd7;

    // Running index (quotient bits shift in at the bottom), partial
    // remainder and accumulated address.
    typedef struct packed {
        logic [IDX_W-1:0]  rest;
        logic [SIZE_W-1:0] rem;
        logic [ADDR_W-1:0] acc;
    } t_word;

endpackage

### design/sita_in_if.sv
// ----------------------------------------------------------------------------
// sita_in_if
// Input channel: one linear element index per word.
// ----------------------------------------------------------------------------
interface sita_in_if;
    logic                       valid;
    logic                       ready;
    logic [sita_pkg::IDX_W-1:0] linear_index;

    modport source (output valid, output linear_index, input ready);
    modport sink   (input valid, input linear_index, output ready);
endinterface

### design/sita_out_if.sv
// ----------------------------------------------------------------------------
// sita_out_if
// Output channel: one storage address per word.
// ----------------------------------------------------------------------------
interface sita_out_if;
    logic                        valid;
    logic                        ready;
    logic [sita_pkg::ADDR_W-1:0] storage_address;

    modport source (output valid, output storage_address, input ready);
    modport sink   (input valid, input storage_address, output ready);
endinterface

### design/sita_div_cell.sv
// ----------------------------------------------------------------------------
// sita_div_cell
// One restoring division step: shift one dividend bit into the partial
// remainder, subtract the divisor when it fits, shift the quotient bit in.
// ----------------------------------------------------------------------------
module sita_div_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  sita_pkg::t_word             i_word,
    input  logic [sita_pkg::SIZE_W-1:0] i_divisor,
    output logic                        o_valid,
    output sita_pkg::t_word             o_word
);
    import sita_pkg::*;

    logic            r_valid;
    t_word           r_word;
    t_word           n_word;
    logic [SIZE_W:0] w_trial;
    logic [SIZE_W:0] w_diff;
    logic            w_fit;

    always_comb begin
        w_trial = {i_word.rem, i_word.rest[IDX_W-1]};
        w_diff  = w_trial - {1'b0, i_divisor};
        w_fit   = (w_trial >= {1'b0, i_divisor});
        n_word.acc  = i_word.acc;
        n_word.rest = {i_word.rest[IDX_W-2:0], w_fit};
        n_word.rem  = w_fit ? w_diff[SIZE_W-1:0] : w_trial[SIZE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_valid && i_divisor != '0 && i_word.rem < i_divisor)
        |=> (r_word.rem < $past(i_divisor)))
        else $error("partial remainder reached the divisor");

endmodule

### design/sita_mac_cell.sv
// ----------------------------------------------------------------------------
// sita_mac_cell
// Closes one dimension: multiply the remainder by the stride, then add it
// into the address and clear the remainder for the next dimension.
// ----------------------------------------------------------------------------
module sita_mac_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  sita_pkg::t_word               i_word,
    input  logic [sita_pkg::SIZE_W-1:0]   i_extent,
    input  logic [sita_pkg::STRIDE_W-1:0] i_stride,
    output logic                          o_valid,
    output sita_pkg::t_word               o_word
);
    import sita_pkg::*;

    logic              r_valid_a;
    t_word             r_word_a;
    logic [PROD_W-1:0] r_prod;
    t_word             n_word_a;
    logic [PROD_W-1:0] n_prod;
    logic              r_valid_b;
    t_word             r_word_b;
    t_word             n_word_b;

    always_comb begin
        n_word_a = i_word;
        n_word_a.rem = '0;
        if (i_extent == '0) begin
            // zero extent: no contribution, outer dimensions see index zero
            n_word_a.rest = '0;
            n_prod        = '0;
        end else begin
            n_prod = i_word.rem * i_stride;
        end
    end

    always_comb begin
        n_word_b     = r_word_a;
        n_word_b.acc = r_word_a.acc + ADDR_W'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else if (i_en) begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word_a <= n_word_a;
            r_prod   <= n_prod;
            r_word_b <= n_word_b;
        end
    end

    assign o_valid = r_valid_b;
    assign o_word  = r_word_b;

    a_zero_extent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_valid && i_extent == '0)
        |=> (r_valid_a && r_word_a.rest == '0 && r_prod == '0))
        else $error("zero extent left a nonzero index or product");

    a_rem_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_valid_a) |=> (r_valid_b && r_word_b.rem == '0))
        else $error("remainder not cleared between dimensions");

endmodule

### design/strided_index_to_address.sv
// ----------------------------------------------------------------------------
// strided_index_to_address
// Turns a row-major linear element index into a storage address of a
// strided view of up to MAX_DIMS dimensions.
// ----------------------------------------------------------------------------
// One index enters and one address leaves every clock cycle while the row
// is not held. Each index runs through a row of cells: per dimension, 48
// one-bit division cells followed by a multiply-add cell with a multiply
// stage and an add stage. Unused outer dimension slots pass the index
// through with no contribution. When the output is not taken and the last
// stage holds an address, the whole row holds; input ready is high whenever
// the row moves. Configuration must only be written while the row is empty.
module strided_index_to_address (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    sita_in_if.sink                          i_item,
    sita_out_if.source                       o_addr,
    input  logic                             i_cfg_we,
    input  logic [sita_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sita_pkg::CFG_W-1:0]       i_cfg_data
);
    import sita_pkg::*;

    localparam int SEG   = IDX_W + 1;
    localparam int NODES = MAX_DIMS * SEG + 1;

    logic [DIM_CNT_W-1:0] r_dim_count;
    logic [SIZE_W-1:0]    r_size   [REG_DIMS];
    logic [STRIDE_W-1:0]  r_stride [REG_DIMS];
    logic [BASE_W-1:0]    r_base;

    logic [DIM_CNT_W-1:0] w_dims;
    logic [DIM_CNT_W-1:0] w_sel;
    logic [SIZE_W-1:0]    w_ext [MAX_DIMS];
    logic [STRIDE_W-1:0]  w_str [MAX_DIMS];

    logic                 w_valid [NODES];
    t_word                w_word  [NODES];
    logic                 w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_count <= DIM_CNT_W'(1);
            for (int d = 0; d < REG_DIMS; d++) begin
                r_size[d]   <= SIZE_W'(1);
                r_stride[d] <= STRIDE_W'(1);
            end
            r_base <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DIM_COUNT: r_dim_count <= i_cfg_data[DIM_CNT_W-1:0];
                REG_SIZE_D0:   r_size[0]   <= i_cfg_data[SIZE_W-1:0];
                REG_SIZE_D1:   r_size[1]   <= i_cfg_data[SIZE_W-1:0];
                REG_SIZE_D2:   r_size[2]   <= i_cfg_data[SIZE_W-1:0];
                REG_STRIDE_D0: r_stride[0] <= i_cfg_data[STRIDE_W-1:0];
                REG_STRIDE_D1: r_stride[1] <= i_cfg_data[STRIDE_W-1:0];
                REG_STRIDE_D2: r_stride[2] <= i_cfg_data[STRIDE_W-1:0];
                REG_BASE:      r_base      <= i_cfg_data[BASE_W-1:0];
                default: ;
            endcase
        end
    end

    // Slot j of the row handles dimension dims-1-j: innermost first.
    always_comb begin
        w_dims = r_dim_count;
        if (w_dims == '0) begin
            w_dims = DIM_CNT_W'(1);
        end
        if (int'(w_dims) > DIM_LIM) begin
            w_dims = DIM_CNT_W'(DIM_LIM);
        end
        w_sel = '0;
        for (int j = 0; j < MAX_DIMS; j++) begin
            if (j < int'(w_dims)) begin
                w_sel    = DIM_CNT_W'(int'(w_dims) - 1 - j);
                w_ext[j] = r_size[w_sel];
                w_str[j] = r_stride[w_sel];
            end else begin
                w_ext[j] = SIZE_W'(1);
                w_str[j] = '0;
            end
        end
    end

    assign w_en          = !w_valid[NODES-1] || o_addr.ready;
    assign i_item.ready  = w_en;

    assign w_valid[0] = i_item.valid;
    assign w_word[0]  = {i_item.linear_index, SIZE_W'(0), ADDR_W'(r_base)};

    for (genvar j = 0; j < MAX_DIMS; j++) begin : g_dim
        for (genvar i = 0; i < IDX_W; i++) begin : g_div
            sita_div_cell u_div (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_en      (w_en),
                .i_valid   (w_valid[j*SEG + i]),
                .i_word    (w_word[j*SEG + i]),
                .i_divisor (w_ext[j]),
                .o_valid   (w_valid[j*SEG + i + 1]),
                .o_word    (w_word[j*SEG + i + 1])
            );
        end
        sita_mac_cell u_mac (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_valid  (w_valid[j*SEG + IDX_W]),
            .i_word   (w_word[j*SEG + IDX_W]),
            .i_extent (w_ext[j]),
            .i_stride (w_str[j]),
            .o_valid  (w_valid[j*SEG + IDX_W + 1]),
            .o_word   (w_word[j*SEG + IDX_W + 1])
        );
    end

    assign o_addr.valid           = w_valid[NODES-1];
    assign o_addr.storage_address = w_word[NODES-1].acc;

    a_first_cell_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && w_en) |=> w_valid[1])
        else $error("accepted word did not enter the first cell");

endmodule
